// ===== hdl/btda_pkg.sv =====
`default_nettype none

package btda_pkg;

   // width of the request value port
   localparam int REQ_VALUE_BITS = 32;

   // one packed bcd digit
   localparam int BCD_DIGIT_BITS = 4;

   // width of the ascii digit result
   localparam int DIGIT_CHAR_BITS = 6;

   // ascii code of the zero character, low six bits
   localparam logic [DIGIT_CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

   // ascii code of the nine character, low six bits
   localparam logic [DIGIT_CHAR_BITS-1:0] ASCII_NINE = 6'd57;

   // decimal digits needed for the largest value of a given width
   // (bits times log10 of two, rounded up; never an exact power of ten)
   function automatic int btda_max_digits(input int bits);
      return (bits * 30103) / 100000 + 1;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/binary_to_decimal_ascii_core.sv =====
// Converts an unsigned binary number to decimal ascii text, most significant digit
// first, leading zeros dropped (zero gives a single '0'); the final digit of each
// number carries rsp_last_digit. A number is transferred when start is high and busy
// low. A chain of VALUE_BITS shift-and-add-three stages, one binary bit per stage,
// builds the bcd digits; a number passes the input register, the stages and the
// serialiser's active and strobe registers before its first digit appears. Digits
// leave one per cycle from a single output serialiser; a number of n digits (1 to 10
// at 32 bits) holds the output while they leave, and the next is taken on its last
// digit. Each digit is on the rsp_ ports for exactly one cycle under rsp_strobe and
// cannot be held off; busy rises only while the chain waits behind the serialiser.
`default_nettype none

module binary_to_decimal_ascii_core
   import btda_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [REQ_VALUE_BITS-1:0]   req_value,
   output logic                             rsp_strobe,
   output logic [DIGIT_CHAR_BITS-1:0]       rsp_digit_char,
   output logic                             rsp_last_digit
);

   localparam int DIGITS = btda_max_digits(VALUE_BITS);

   logic                                   advance;
   logic                                   take;
   logic [VALUE_BITS-1:0]                  value_masked;
   logic                                   s_valid [0:VALUE_BITS];
   logic [VALUE_BITS-1:0]                  s_bin   [0:VALUE_BITS];
   logic [DIGITS-1:0][BCD_DIGIT_BITS-1:0]  s_bcd   [0:VALUE_BITS];
   logic                                   in_valid_ff;
   logic [VALUE_BITS-1:0]                  in_bin_ff;

   // fit the request value to the conversion width
   generate
      if (VALUE_BITS > REQ_VALUE_BITS) begin : g_widen
         assign value_masked = {{(VALUE_BITS-REQ_VALUE_BITS){1'b0}}, req_value};
      end else if (VALUE_BITS == REQ_VALUE_BITS) begin : g_same
         assign value_masked = req_value;
      end else begin : g_narrow
         assign value_masked = req_value[VALUE_BITS-1:0];
      end
   endgenerate

   // whole chain moves unless its last stage is blocked by the serialiser
   assign advance = !s_valid[VALUE_BITS] || take;
   assign busy    = !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_bin_ff <= value_masked;
      end
   end

   assign s_valid[0] = in_valid_ff;
   assign s_bin[0]   = in_bin_ff;
   assign s_bcd[0]   = '0;

   // one stage per binary bit
   generate
      for (genvar g = 0; g < VALUE_BITS; g++) begin : g_stage
         btda_dabble_stage #(
            .VALUE_BITS (VALUE_BITS),
            .DIGITS     (DIGITS)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .in_valid  (s_valid[g]),
            .in_bin    (s_bin[g]),
            .in_bcd    (s_bcd[g]),
            .out_valid (s_valid[g+1]),
            .out_bin   (s_bin[g+1]),
            .out_bcd   (s_bcd[g+1])
         );
      end
   endgenerate

   // digit output
   btda_serializer #(
      .DIGITS (DIGITS)
   ) u_serializer (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s_valid[VALUE_BITS]),
      .in_bcd         (s_bcd[VALUE_BITS]),
      .take           (take),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   // every emitted character is a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_digit_char >= ASCII_ZERO) && (rsp_digit_char <= ASCII_NINE))
      else $error("non-decimal character emitted");

   // a run is not broken before its last digit
   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_digit) |=> rsp_strobe)
      else $error("digit run ended without last flag");

   // a blocked chain end holds its number
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s_valid[VALUE_BITS] && !take) |=> (s_valid[VALUE_BITS] && $stable(s_bcd[VALUE_BITS])))
      else $error("stalled conversion result changed");

endmodule

`default_nettype wire

// ===== hdl/btda_dabble_stage.sv =====
`default_nettype none

module btda_dabble_stage
   import btda_pkg::*;
#(
   parameter int VALUE_BITS = 32,
   parameter int DIGITS     = 10
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   advance,
   input  wire logic                                   in_valid,
   input  wire logic [VALUE_BITS-1:0]                  in_bin,
   input  wire logic [DIGITS-1:0][BCD_DIGIT_BITS-1:0]  in_bcd,
   output logic                                        out_valid,
   output logic [VALUE_BITS-1:0]                       out_bin,
   output logic [DIGITS-1:0][BCD_DIGIT_BITS-1:0]       out_bcd
);

   logic                                   valid_ff;
   logic [VALUE_BITS-1:0]                  bin_ff;
   logic [VALUE_BITS-1:0]                  bin_in;
   logic [DIGITS-1:0][BCD_DIGIT_BITS-1:0]  bcd_ff;
   logic [DIGITS-1:0][BCD_DIGIT_BITS-1:0]  bcd_adj;
   logic [DIGITS-1:0][BCD_DIGIT_BITS-1:0]  bcd_in;
   logic [DIGITS*BCD_DIGIT_BITS:0]         shift_wide;

   // add three to every digit of five or more, then shift in the next binary bit
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (in_bcd[i] >= 4'd5) begin
            bcd_adj[i] = in_bcd[i] + 4'd3;
         end else begin
            bcd_adj[i] = in_bcd[i];
         end
      end
      shift_wide = {bcd_adj, in_bin[VALUE_BITS-1]};
      bcd_in     = shift_wide[DIGITS*BCD_DIGIT_BITS-1:0];
      bin_in     = {in_bin[VALUE_BITS-2:0], 1'b0};
   end

   // valid bit is control state, payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bin_ff <= bin_in;
         bcd_ff <= bcd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bin   = bin_ff;
   assign out_bcd   = bcd_ff;

endmodule

`default_nettype wire

// ===== hdl/btda_serializer.sv =====
`default_nettype none

module btda_serializer
   import btda_pkg::*;
#(
   parameter int DIGITS = 10
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire logic [DIGITS-1:0][BCD_DIGIT_BITS-1:0]  in_bcd,
   output logic                                        take,
   output logic                                        rsp_strobe,
   output logic [DIGIT_CHAR_BITS-1:0]                  rsp_digit_char,
   output logic                                        rsp_last_digit
);

   localparam int IDX_W = $clog2(DIGITS);

   logic                                   active_ff;
   logic                                   active_in;
   logic [DIGITS-1:0][BCD_DIGIT_BITS-1:0]  bcd_ff;
   logic [DIGITS-1:0][BCD_DIGIT_BITS-1:0]  bcd_in;
   logic [IDX_W-1:0]                       idx_ff;
   logic [IDX_W-1:0]                       idx_in;
   logic [IDX_W-1:0]                       lead_idx;
   logic                                   load;
   logic                                   strobe_ff;
   logic [DIGIT_CHAR_BITS-1:0]             char_ff;
   logic [DIGIT_CHAR_BITS-1:0]             char_in;
   logic                                   last_ff;

   // most significant non-zero digit, zero value gives the ones digit
   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (in_bcd[i] != '0) begin
            lead_idx = IDX_W'(i);
         end
      end
   end

   // a new number is taken when idle or on the last digit of the current one
   assign take = !active_ff || (idx_ff == '0);
   assign load = in_valid && take;

   // digit walk from the leading digit down to the ones digit
   always_comb begin
      active_in = active_ff;
      bcd_in    = bcd_ff;
      idx_in    = idx_ff;
      if (active_ff) begin
         if (idx_ff == '0) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
      if (load) begin
         active_in = 1'b1;
         bcd_in    = in_bcd;
         idx_in    = lead_idx;
      end
   end

   // ascii character of the current digit
   assign char_in = ASCII_ZERO + {{(DIGIT_CHAR_BITS-BCD_DIGIT_BITS){1'b0}}, bcd_ff[idx_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff  <= bcd_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= (idx_ff == '0);
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule

`default_nettype wire
